// ===== sv/cle_pkg.sv =====
package cle_pkg;

    // defaults for the top level parameters
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEVEL_BITS_DEF  = 24;

    localparam int MAX_HEIGHT  = 4096;
    localparam int COORD_BITS  = 12;
    localparam int SIZE_BITS   = 13;
    localparam int SCALE_BITS  = 24;
    localparam int CFG_BITS    = 24;
    localparam int FRAC_BITS   = 16;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SCALE  = 2'd2
    } t_cfg_idx;

    localparam logic [SIZE_BITS-1:0]  WIDTH_RST  = SIZE_BITS'(256);
    localparam logic [SIZE_BITS-1:0]  HEIGHT_RST = SIZE_BITS'(256);
    localparam logic [SCALE_BITS-1:0] SCALE_RST  = SCALE_BITS'(65536);

    typedef struct packed {
        logic                  edge_res;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row_index;
        logic                  frame_end;
        logic                  run_last;
    } t_result;

endpackage

// ===== sv/cle_in_if.sv =====
interface cle_in_if import cle_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

// ===== sv/cle_out_if.sv =====
interface cle_out_if import cle_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  edge_res;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row_index;
    logic                  frame_end;
    logic                  run_last;

    modport source (output valid, output edge_res, output col, output row_index,
                    output frame_end, output run_last, input ready);
    modport sink   (input valid, input edge_res, input col, input row_index,
                    input frame_end, input run_last, output ready);
endinterface

// ===== sv/cle_res_fifo.sv =====
// Two-entry result queue; decouples the pipeline from output stalls.
module cle_res_fifo import cle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);
    t_result    r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;
    logic       push;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_cnt != 2'd2) || pop;
    assign push    = i_push && o_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_data;
        end
    end
endmodule

// ===== sv/contour_line_extractor.sv =====
// Channel  Dir  Beat payload                                    Handshake
// i_px     in   height_sample                                   valid/ready
// o_px     out  edge_res, col, row_index, frame_end, run_last   valid/ready
// cfg      in   i_cfg_idx, i_cfg_data                           i_cfg_we
//
// One sample per clock unless the output stalls: stage A takes the beat and runs
// the multiply while the line stores are read, stage B rounds, compares and writes
// both stores back; each result then passes through the result queue to o_px.
// Samples of the last row give two results each, so that row takes a new sample
// only after both of its results are queued, limited by the single output port.
// Synchronous reset clears counters and valids; line stores are not cleared.
// Output stalls back up through a two-entry result queue into both stages.
module contour_line_extractor import cle_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    cle_in_if.sink              i_px,
    cle_out_if.source           o_px
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WVW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WVW > SIZE_BITS) ? WVW : SIZE_BITS;
    localparam int PW    = SAMPLE_BITS + SCALE_BITS;
    localparam int QRW   = PW + 1 - FRAC_BITS;
    localparam int QW    = ((QRW > LEVEL_BITS) ? QRW : LEVEL_BITS) + 1;
    localparam logic [QW-1:0] LMAX = (QW'(1) << (LEVEL_BITS - 1)) - QW'(1);
    localparam logic [PW:0]   HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    // configuration
    logic [SIZE_BITS-1:0]  r_cfg_width;
    logic [SIZE_BITS-1:0]  r_cfg_height;
    logic [SCALE_BITS-1:0] r_cfg_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
            r_cfg_scale  <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_data[SIZE_BITS-1:0];
                CFG_SCALE:  r_cfg_scale  <= i_cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [CMPW-1:0]      w_ext;
    logic [CMPW-1:0]      w_eff;
    logic [SIZE_BITS-1:0] h_eff;

    always_comb begin
        w_ext = CMPW'(r_cfg_width);
        if (w_ext < CMPW'(3)) begin
            w_eff = CMPW'(3);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_cfg_height < SIZE_BITS'(3)) begin
            h_eff = SIZE_BITS'(3);
        end else if (r_cfg_height > SIZE_BITS'(MAX_HEIGHT)) begin
            h_eff = SIZE_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    // raster position of the next input beat
    logic [CW-1:0]         r_col;
    logic [COORD_BITS-1:0] r_row;
    logic                  in_row_end;
    logic                  in_last_row;
    logic                  in_acc;

    assign in_row_end  = CMPW'(r_col) >= (w_eff - CMPW'(1));
    assign in_last_row = {1'b0, r_row} >= (h_eff - SIZE_BITS'(1));
    assign in_acc      = i_px.valid && i_px.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (in_row_end) begin
                r_col <= '0;
                r_row <= in_last_row ? '0 : r_row + COORD_BITS'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage A: accepted beat
    logic                          r_a_valid;
    logic signed [SAMPLE_BITS-1:0] r_a_sample;
    logic [CW-1:0]                 r_a_x;
    logic [COORD_BITS-1:0]         r_a_y;
    logic                          r_a_row_end;
    logic                          r_a_last_row;
    logic                          a_adv;
    logic                          a_neg;
    logic [SAMPLE_BITS-1:0]        a_mag;
    logic [CW-1:0]                 a_rd_next;

    // stage B: levels and result generation
    logic                  r_b_valid;
    logic [PW-1:0]         r_b_prod;
    logic                  r_b_neg;
    logic [CW-1:0]         r_b_x;
    logic [COORD_BITS-1:0] r_b_y;
    logic                  r_b_row_end;
    logic                  r_b_last_row;
    logic                  r_b_phase;
    logic                  b_done;

    assign a_adv      = r_a_valid && (!r_b_valid || b_done);
    assign i_px.ready = !r_a_valid || a_adv;

    assign a_neg     = r_a_sample[SAMPLE_BITS-1];
    assign a_mag     = a_neg ? SAMPLE_BITS'(-r_a_sample) : SAMPLE_BITS'(r_a_sample);
    // look one column ahead in the newer row; wraps to column 0 for the next row
    assign a_rd_next = r_a_row_end ? '0 : r_a_x + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_px.ready) begin
            r_a_valid <= i_px.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sample   <= i_px.height_sample;
            r_a_x        <= r_col;
            r_a_y        <= r_row;
            r_a_row_end  <= in_row_end;
            r_a_last_row <= in_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_prod     <= PW'(a_mag) * PW'(r_cfg_scale);
            r_b_neg      <= a_neg;
            r_b_x        <= r_a_x;
            r_b_y        <= r_a_y;
            r_b_row_end  <= r_a_row_end;
            r_b_last_row <= r_a_last_row;
        end
    end

    // line stores
    logic [LEVEL_BITS-1:0] r_older_mem [MAX_WIDTH];
    logic [LEVEL_BITS-1:0] r_newer_mem [MAX_WIDTH];
    logic [LEVEL_BITS-1:0] r_old_q;
    logic [LEVEL_BITS-1:0] r_new_q;
    logic [LEVEL_BITS-1:0] r_nb1;     // newer row, this column
    logic [LEVEL_BITS-1:0] r_nb2;     // newer row, left column
    logic [LEVEL_BITS-1:0] b_level;

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_old_q <= r_older_mem[r_a_x];
            r_new_q <= r_newer_mem[a_rd_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done) begin
            r_older_mem[r_b_x] <= r_nb1;
            r_newer_mem[r_b_x] <= b_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done) begin
            r_nb1 <= r_new_q;
            r_nb2 <= r_nb1;
        end
    end

    // round half away from zero, saturate to the signed level range
    logic [PW:0]     b_sum;
    logic [QW-1:0]   b_q;
    logic [QW-1:0]   b_qsat;

    always_comb begin
        b_sum = {1'b0, r_b_prod} + HALF;
        b_q   = QW'(b_sum >> FRAC_BITS);
        if (r_b_neg) begin
            b_qsat  = (b_q > LMAX + QW'(1)) ? LMAX + QW'(1) : b_q;
            b_level = LEVEL_BITS'(-b_qsat);
        end else begin
            b_qsat  = (b_q > LMAX) ? LMAX : b_q;
            b_level = LEVEL_BITS'(b_qsat);
        end
    end

    logic    b_has_first;
    logic    b_inner;
    logic    b_edge;
    logic    b_is_first;
    logic    b_final;
    logic    b_any;
    logic    q_room;
    logic    b_push;
    t_result b_res;

    assign b_has_first = (r_b_y != '0);
    assign b_any       = b_has_first || r_b_last_row;
    assign b_inner     = (r_b_x != '0) && !r_b_row_end && (r_b_y >= COORD_BITS'(2));
    assign b_edge      = b_inner && ((r_nb2 != r_new_q) || (r_old_q != b_level));
    assign b_is_first  = !r_b_phase && b_has_first;
    assign b_final     = !(b_is_first && r_b_last_row);
    assign b_push      = r_b_valid && b_any;
    assign b_done      = r_b_valid && (!b_any || (q_room && b_final));

    always_comb begin
        if (b_is_first) begin
            b_res.edge_res  = b_edge;
            b_res.row_index = r_b_y - COORD_BITS'(1);
            b_res.frame_end = 1'b0;
            b_res.run_last  = !r_b_last_row;
        end else begin
            b_res.edge_res  = 1'b0;
            b_res.row_index = r_b_y;
            b_res.frame_end = r_b_row_end;
            b_res.run_last  = 1'b1;
        end
        b_res.col = COORD_BITS'(r_b_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_phase <= 1'b0;
        end else if (b_done) begin
            r_b_phase <= 1'b0;
        end else if (b_push && q_room) begin
            r_b_phase <= 1'b1;
        end
    end

    t_result q_res;

    cle_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_res),
        .o_room  (q_room),
        .o_valid (o_px.valid),
        .o_data  (q_res),
        .i_ready (o_px.ready)
    );

    assign o_px.edge_res  = q_res.edge_res;
    assign o_px.col       = q_res.col;
    assign o_px.row_index = q_res.row_index;
    assign o_px.frame_end = q_res.frame_end;
    assign o_px.run_last  = q_res.run_last;

endmodule
